// File: hdl/gbci_pkg.sv
// ---------------------------------------------------------------------------
// gbci_pkg: shared types and constants of the box cell index unit
// Scheme codes, register indexes, the configuration bundle and the
// constants of the order hash.
// ---------------------------------------------------------------------------
`default_nettype none

package gbci_pkg;

  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned SCHEME_W = 2;
  localparam int unsigned CFG_W    = 5;

  // Register indexes on the configuration port.
  localparam logic REG_GRID_LEVEL  = 1'b0;
  localparam logic REG_GRID_SCHEME = 1'b1;

  typedef enum logic [SCHEME_W-1:0] {
    SCH_FLAT  = 2'd0,
    SCH_FLAT4 = 2'd1,
    SCH_TREE  = 2'd2,
    SCH_TREE3 = 2'd3
  } scheme_e;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    scheme_e            scheme;
  } cfg_t;

  // Order hash constants.
  localparam logic [63:0] HASH_ADD  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_MUL2 = 64'h94d049bb133111eb;

endpackage

`default_nettype wire

// File: hdl/gbci_hash.sv
// ---------------------------------------------------------------------------
// gbci_hash: three-stage order hash
// Computes the two low bits of the mixing hash of a 64-bit word; each
// 64-bit multiply is split into 32-bit partial products over one stage.
// ---------------------------------------------------------------------------
`default_nettype none

module gbci_hash (
  input  wire logic        clk_i,
  input  wire logic [63:0] x_i,
  output      logic [1:0]  h_o
);

  logic [63:0] a1, t1, m1, t2, m2;
  logic [63:0] ll1_q, ll2_q;
  logic [31:0] lh1_q, hl1_q, lh2_q, hl2_q;
  logic [63:0] ll1_d, ll2_d;
  logic [31:0] lh1_d, hl1_d, lh2_d, hl2_d;
  logic [1:0]  h_q;

  // First mix round and its partial products.
  always_comb begin
    a1    = x_i + gbci_pkg::HASH_ADD;
    t1    = a1 ^ (a1 >> 30);
    ll1_d = 64'(t1[31:0]) * 64'(gbci_pkg::HASH_MUL1[31:0]);
    lh1_d = t1[31:0] * gbci_pkg::HASH_MUL1[63:32];
    hl1_d = t1[63:32] * gbci_pkg::HASH_MUL1[31:0];
  end

  // Second round: finish the first product, start the second.
  always_comb begin
    m1    = ll1_q + {lh1_q + hl1_q, 32'd0};
    t2    = m1 ^ (m1 >> 27);
    ll2_d = 64'(t2[31:0]) * 64'(gbci_pkg::HASH_MUL2[31:0]);
    lh2_d = t2[31:0] * gbci_pkg::HASH_MUL2[63:32];
    hl2_d = t2[63:32] * gbci_pkg::HASH_MUL2[31:0];
  end

  assign m2 = ll2_q + {lh2_q + hl2_q, 32'd0};

  always_ff @(posedge clk_i) begin
    ll1_q <= ll1_d;
    lh1_q <= lh1_d;
    hl1_q <= hl1_d;
    ll2_q <= ll2_d;
    lh2_q <= lh2_d;
    hl2_q <= hl2_d;
    h_q   <= m2[1:0] ^ m2[32:31];
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

// File: hdl/gbci_geom.sv
// ---------------------------------------------------------------------------
// gbci_geom: three-stage grid geometry
// Quantizes the corners for every copy, compares cells and finds the
// common quadtree ancestor, then forms the result of the chosen scheme.
// ---------------------------------------------------------------------------
`default_nettype none

module gbci_geom #(
  parameter int unsigned MAX_LEVEL       = 24,
  parameter int unsigned COORD_FRAC_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire gbci_pkg::cfg_t               cfg_i,
  input  wire logic [COORD_FRAC_BITS:0]     u_low_i,
  input  wire logic [COORD_FRAC_BITS:0]     v_low_i,
  input  wire logic [COORD_FRAC_BITS:0]     u_high_i,
  input  wire logic [COORD_FRAC_BITS:0]     v_high_i,
  output      logic [3:0]                   match_o,
  output      logic [2*MAX_LEVEL-1:0]       idx_o [4],
  output      logic [2*MAX_LEVEL+2:0]       res_o
);

  localparam int unsigned ML  = MAX_LEVEL;
  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned CW  = F + 1;
  localparam int unsigned SW  = CW + ML + 1;
  localparam int unsigned IW  = 2 * ML;
  localparam int unsigned CLW = IW + 1;
  localparam int unsigned OW  = IW + 3;
  localparam logic [F:0]   ONE_Q   = {1'b1, {F{1'b0}}};
  localparam logic [F:0]   THIRD_W = ONE_Q / 3;
  localparam logic [F-1:0] OFF1    = THIRD_W[F-1:0];
  localparam logic [F-1:0] OFF2    = F'(THIRD_W * 2 + 1);

  function automatic logic [ML-1:0] clamp_q(input logic [SW-1:0] q, input logic [4:0] lv);
    logic [SW-1:0] top;
    top = (SW'(1) << lv) - SW'(1);
    return (q > top) ? top[ML-1:0] : q[ML-1:0];
  endfunction

  function automatic logic [ML-1:0] plain_coord(input logic [CW-1:0] c, input logic [4:0] lv);
    logic [SW-1:0] q;
    q = (SW'(c) << lv) >> F;
    return clamp_q(q, lv);
  endfunction

  function automatic logic [ML-1:0] half_coord(input logic [CW-1:0] c, input logic [4:0] lv);
    logic [SW-1:0] q;
    q = (SW'(c) << ({1'b0, lv} + 6'd1)) >> F;
    if (q == '0) begin
      return '0;
    end
    return clamp_q((q - SW'(1)) >> 1, lv);
  endfunction

  function automatic logic [IW-1:0] interleave(input logic [ML-1:0] x, input logic [ML-1:0] y);
    logic [IW-1:0] r;
    for (int i = 0; i < ML; i++) begin
      r[2*i]   = x[i];
      r[2*i+1] = y[i];
    end
    return r;
  endfunction

  logic [CW-1:0] c_in [4];
  assign c_in[0] = u_low_i;
  assign c_in[1] = v_low_i;
  assign c_in[2] = u_high_i;
  assign c_in[3] = v_high_i;

  // Stage one: quantized coordinates for every copy.
  logic [ML-1:0] px_d [4], sx_d [4], px_q [4], sx_q [4];
  logic [ML-1:0] ox_d [3][4], ox_q [3][4];
  logic [2:0]    inv_d, inv_q;
  logic [F-1:0]  wr [3][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px_d[k] = plain_coord(c_in[k], cfg_i.level);
      sx_d[k] = half_coord(c_in[k], cfg_i.level);
      wr[0][k] = c_in[k][F-1:0];
      wr[1][k] = c_in[k][F-1:0] + OFF1;
      wr[2][k] = c_in[k][F-1:0] + OFF2;
    end
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 4; k++) begin
        ox_d[s][k] = plain_coord({1'b0, wr[s][k]}, cfg_i.level);
      end
      inv_d[s] = (wr[s][2] < wr[s][0]) || (wr[s][3] < wr[s][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    sx_q  <= sx_d;
    ox_q  <= ox_d;
    inv_q <= inv_d;
  end

  // Stage two: flat copy matches and ancestor depth of each tree.
  logic [3:0]    match_d, match_q;
  logic [IW-1:0] idx_d [4], idx_q [4];
  logic [4:0]    dep_d [4], dep_q [4];
  logic [IW-1:0] il_d [4], il_q [4];
  logic [ML-1:0] fx1, fx2, fy1, fy2;
  logic [ML-1:0] tx1 [4], ty1 [4], tx2 [4], ty2 [4];
  logic [ML-1:0] diff;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fx1 = k[0] ? sx_q[0] : px_q[0];
      fx2 = k[0] ? sx_q[2] : px_q[2];
      fy1 = k[1] ? sx_q[1] : px_q[1];
      fy2 = k[1] ? sx_q[3] : px_q[3];
      match_d[k] = (fx1 == fx2) && (fy1 == fy2);
      idx_d[k]   = (IW'(fy1) << cfg_i.level) | IW'(fx1);
    end
    tx1[0] = px_q[0]; ty1[0] = px_q[1]; tx2[0] = px_q[2]; ty2[0] = px_q[3];
    for (int s = 0; s < 3; s++) begin
      tx1[s+1] = ox_q[s][0];
      ty1[s+1] = ox_q[s][1];
      tx2[s+1] = ox_q[s][2];
      ty2[s+1] = ox_q[s][3];
    end
    for (int t = 0; t < 4; t++) begin
      diff     = (tx1[t] ^ tx2[t]) | (ty1[t] ^ ty2[t]);
      dep_d[t] = '0;
      for (int i = 0; i < ML; i++) begin
        if (diff[i]) begin
          dep_d[t] = 5'(i + 1);
        end
      end
      // A wrapped copy collapses to the root cell.
      if (t > 0 && inv_q[t-1]) begin
        dep_d[t] = cfg_i.level;
      end
      il_d[t] = interleave(tx1[t], ty1[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    idx_q   <= idx_d;
    dep_q   <= dep_d;
    il_q    <= il_d;
  end

  // Stage three: cells, best shifted tree and per-scheme result. The flat
  // matches and indexes are carried one more stage so they leave together
  // with the result of the same word.
  logic [CLW-1:0] tcell [4];
  logic [CLW-1:0] mask;
  logic [5:0]     sh;
  logic [1:0]     best;
  logic [OW-1:0]  res_d, res_q;
  logic [3:0]     match3_q;
  logic [IW-1:0]  idx3_q [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      sh       = {dep_q[t], 1'b0};
      mask     = (CLW'(1) << sh) - CLW'(1);
      tcell[t] = ((CLW'(il_q[t]) & ~mask) << 1) | (CLW'(1) << sh);
    end
    best = 2'd0;
    for (int s = 1; s < 3; s++) begin
      if (dep_q[s+1] < dep_q[best+2'd1]) begin
        best = 2'(s);
      end
    end
    unique case (cfg_i.scheme)
      gbci_pkg::SCH_FLAT: begin
        res_d = match_q[0] ? OW'(idx_q[0])
                           : (OW'(1) << {cfg_i.level, 1'b0}) - OW'(1);
      end
      gbci_pkg::SCH_TREE: begin
        res_d = OW'(tcell[0]);
      end
      gbci_pkg::SCH_TREE3: begin
        res_d = (OW'(best) << ({cfg_i.level, 1'b0} + 6'd1)) | OW'(tcell[best+2'd1]);
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    match3_q <= match_q;
    idx3_q   <= idx_q;
  end

  assign match_o = match3_q;
  assign idx_o   = idx3_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: hdl/geo_box_cell_index_unit.sv
// ---------------------------------------------------------------------------
// geo_box_cell_index_unit: grid cell index of a bounding box
// Pipelined cell assignment under the flat, shifted flat, quadtree and
// shifted quadtree schemes.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   --------------------------------
//  command   start (in), busy (out)       u_low_i, v_low_i, u_high_i,
//                                         v_high_i, lower_left_bits_i,
//                                         upper_right_bits_i
//  result    done_o (one-cycle strobe)    cell_index_o
//  config    cfg_we_i, cfg_idx_i          cfg_wdata_i
//
// One word enters per cycle; busy never rises. An accepted word is
// shown on cell_index_o with done_o after the input register, three
// geometry stages and the output register; the order hash runs
// alongside in three stages, the first two of 32-bit partial products.
// Reset clears the valid line and resets the configuration registers
// (level 1, flat scheme); words in flight at reset are dropped. The
// receiver cannot stall: each result stands for exactly one cycle.
//
`default_nettype none

module geo_box_cell_index_unit #(
  parameter int unsigned MAX_LEVEL       = 24,
  parameter int unsigned COORD_FRAC_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [COORD_FRAC_BITS:0]      u_low_i,
  input  wire logic [COORD_FRAC_BITS:0]      v_low_i,
  input  wire logic [COORD_FRAC_BITS:0]      u_high_i,
  input  wire logic [COORD_FRAC_BITS:0]      v_high_i,
  input  wire logic [63:0]                   lower_left_bits_i,
  input  wire logic [63:0]                   upper_right_bits_i,
  output      logic                          done_o,
  output      logic [2*MAX_LEVEL+2:0]        cell_index_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [gbci_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IW = 2 * MAX_LEVEL;
  localparam int unsigned OW = IW + 3;
  localparam int unsigned LAT = 4;

  // Configuration registers.
  logic [gbci_pkg::LEVEL_W-1:0] level_q;
  gbci_pkg::scheme_e            scheme_q;
  gbci_pkg::cfg_t               cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= gbci_pkg::LEVEL_W'(1);
      scheme_q <= gbci_pkg::SCH_FLAT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gbci_pkg::REG_GRID_LEVEL) begin
        level_q <= cfg_wdata_i[gbci_pkg::LEVEL_W-1:0];
      end else begin
        scheme_q <= gbci_pkg::scheme_e'(cfg_wdata_i[gbci_pkg::SCHEME_W-1:0]);
      end
    end
  end

  // Out-of-range levels fold onto the nearest legal depth.
  always_comb begin
    cfg.scheme = scheme_q;
    if (level_q == '0) begin
      cfg.level = gbci_pkg::LEVEL_W'(1);
    end else if (level_q > gbci_pkg::LEVEL_W'(MAX_LEVEL)) begin
      cfg.level = gbci_pkg::LEVEL_W'(MAX_LEVEL);
    end else begin
      cfg.level = level_q;
    end
  end

  assign busy = 1'b0;

  // Input register; the payload loads every cycle, the valid line marks words.
  logic [LAT-1:0]           vld_q;
  logic [COORD_FRAC_BITS:0] u1_q, v1_q, u2_q, v2_q;
  logic [63:0]              x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q <= u_low_i;
    v1_q <= v_low_i;
    u2_q <= u_high_i;
    v2_q <= v_high_i;
    x_q  <= lower_left_bits_i ^ (upper_right_bits_i << 1);
  end

  logic [1:0]    h;
  logic [3:0]    match;
  logic [IW-1:0] idx [4];
  logic [OW-1:0] geo_res;

  gbci_hash u_hash (
    .clk_i (clk_i),
    .x_i   (x_q),
    .h_o   (h)
  );

  gbci_geom #(
    .MAX_LEVEL       (MAX_LEVEL),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_geom (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .u_low_i  (u1_q),
    .v_low_i  (v1_q),
    .u_high_i (u2_q),
    .v_high_i (v2_q),
    .match_o  (match),
    .idx_o    (idx),
    .res_o    (geo_res)
  );

  // Shifted flat scheme: the hash picks the first copy to try, the rest
  // follow in rotation; if no copy holds the box, the wide sentinel. Other schemes pass the geometry result.
  logic [OW-1:0] res_d, res_q;
  logic [1:0]    s;
  logic          found;

  always_comb begin
    res_d = (OW'(1) << ({cfg.level, 1'b0} + 6'd2)) - OW'(1);
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s = h + 2'(i);
      if (!found && match[s]) begin
        res_d = (OW'(s) << {cfg.level, 1'b0}) | OW'(idx[s]);
        found = 1'b1;
      end
    end
    if (cfg.scheme != gbci_pkg::SCH_FLAT4) begin
      res_d = geo_res;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o       = done_q;
  assign cell_index_o = res_q;

  // Every accepted word comes out with a done_o strobe.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("accepted word did not come out after the pipeline latency");

  // No result appears without an accepted word behind it.
  a_no_ghost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 5))
    else $error("result strobe without an accepted word");

  // A flat result never exceeds the flat sentinel.
  a_flat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg.scheme == gbci_pkg::SCH_FLAT) |->
      (cell_index_o <= (OW'(1) << {cfg.level, 1'b0}) - OW'(1)))
    else $error("flat cell index above sentinel");

endmodule

`default_nettype wire
